// ----- rtl/core/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque core: operation codes,
// field widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;
    // ok, popped, front, rear, full, empty = 99 bits, padded to whole bytes
    localparam int OUT_W  = 104;

    // Operation codes; codes above pop back behave as a query
    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;

    // Value reported for front and rear of an empty deque
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic fetch;    // read the slot a pop would remove
        logic update;   // move pointers, write pushed value, capture popped value
        logic peek;     // read the new front and rear slots
        logic load;     // fill the output register
    } cdq_cmd_t;

    typedef struct packed {
        logic out_free; // output register empty or being drained
    } cdq_status_t;

endpackage

// ----- rtl/core/cdq_ram.sv -----
// ----------------------------------------------------------------------------
// cdq_ram
// Generic RAM: one write port, two read ports sharing a read enable,
// registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- rtl/core/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdq_ctrl
// Operation sequencer: accept a beat, fetch the pop slot, update the ring,
// peek at both ends, then hand the result to the output register.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  cdq_status_t status,
    output cdq_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_PEEK   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_PEEK;
            end
            S_PEEK:
            begin
                cmd.peek   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/cdq_dpath.sv -----
// ----------------------------------------------------------------------------
// cdq_dpath
// Deque datapath: head/tail pointers, empty flag, ring memory, and the
// output register that carries one result beat.
// ----------------------------------------------------------------------------
module cdq_dpath
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cdq_cmd_t          cmd,
    output cdq_status_t       status,
    input  logic [FUNC_W-1:0] s_tuser,
    input  logic [DATA_W-1:0] s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    logic [FUNC_W-1:0]        func_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic [AW-1:0]            head_reg;
    logic [AW-1:0]            head_next;
    logic [AW-1:0]            tail_reg;
    logic [AW-1:0]            tail_next;
    logic                     empty_reg;
    logic                     empty_next;
    logic                     ok_reg;
    logic                     ok_next;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] popped_next;
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         out_data_reg;
    logic [OUT_W-1:0]         out_data_next;

    logic                     is_push;
    logic                     is_pop;
    logic                     full_now;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [AW-1:0]            pop_slot;
    logic [AW-1:0]            raddr_a;
    logic [DATA_W-1:0]        rdata_a;
    logic [DATA_W-1:0]        rdata_b;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;

    // Capture the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= s_tuser;
            data_reg <= s_tdata;
        end
    end

    // Decode and pointer moves
    always_comb
    begin
        is_push     = func_reg inside {OP_PUSH_FRONT, OP_PUSH_BACK};
        is_pop      = func_reg inside {OP_POP_FRONT, OP_POP_BACK};
        full_now    = !empty_reg && (step_up(tail_reg) == head_reg);
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        ok_next     = 1'b1;
        popped_next = '0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        if (is_push)
        begin
            ok_next = !full_now;
            if (!full_now)
            begin
                ram_we = cmd.update;
                if (empty_reg)
                begin
                    // first value lands in slot zero
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                end
                else if (func_reg == OP_PUSH_FRONT)
                begin
                    head_next = step_down(head_reg);
                    ram_waddr = head_next;
                end
                else
                begin
                    tail_next = step_up(tail_reg);
                    ram_waddr = tail_next;
                end
            end
        end
        else if (is_pop)
        begin
            ok_next = !empty_reg;
            if (!empty_reg)
            begin
                popped_next = rdata_a;
                if (head_reg == tail_reg)
                begin
                    // last value gone: rewind both pointers
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end
                else if (func_reg == OP_POP_FRONT)
                begin
                    head_next = step_up(head_reg);
                end
                else
                begin
                    tail_next = step_down(tail_reg);
                end
            end
        end
    end

    // Pointer state and per-item results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else if (cmd.update)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            ok_reg     <= ok_next;
            popped_reg <= popped_next;
        end
    end

    // Port A reads the pop slot on fetch and the front on peek; port B the rear
    assign pop_slot = (func_reg == OP_POP_FRONT) ? head_reg : tail_reg;
    assign raddr_a  = cmd.peek ? head_reg : pop_slot;

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (data_reg),
        .re      (cmd.fetch | cmd.peek),
        .raddr_a (raddr_a),
        .raddr_b (tail_reg),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Assemble the result beat
    always_comb
    begin
        front_value   = empty_reg ? EMPTY_VALUE : rdata_a;
        rear_value    = empty_reg ? EMPTY_VALUE : rdata_b;
        out_data_next = '0;
        out_data_next[0]     = ok_reg;
        out_data_next[32:1]  = popped_reg;
        out_data_next[64:33] = front_value;
        out_data_next[96:65] = rear_value;
        out_data_next[97]    = full_now;
        out_data_next[98]    = empty_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

endmodule

// ----- rtl/core/circular_deque_core.sv -----
// ----------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue of signed 32-bit words in a ring of DEPTH slots.
// Sequence: an accepted input beat runs through the fetch, update and peek states around the
//   registered-read ring memory, then its result is loaded into the output register once that
//   is free; no new beat is accepted until then.
// Reset: asynchronous, active low; the deque comes up empty, pointers at 0.
//   Ring contents are not cleared, only slots already written are ever used in a result.
// ----------------------------------------------------------------------------
module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] data_value
    input  logic [FUNC_W-1:0] s_tuser,   // [2:0] func
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] ok, [32:1] popped_value, [64:33] front_value, [96:65] rear_value,
    // [97] is_full, [98] is_empty, [103:99] zero
    output logic [OUT_W-1:0]  m_tdata
);

    cdq_cmd_t    cmd;
    cdq_status_t status;

    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/core/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the circular deque core, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker
    import cdq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [31:0]       s_tdata,
    input logic [FUNC_W-1:0] s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata
);

    // One operation in flight: no new beat right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an operation is in flight");

    // Full and empty never reported together
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[97] && m_tdata[98]))
        else $error("full and empty both set");

    // Empty deque reports -1 at both ends
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[98]) |-> (m_tdata[64:33] == EMPTY_VALUE
                                       && m_tdata[96:65] == EMPTY_VALUE))
        else $error("empty deque with ends not -1");

    // A refused operation pops nothing
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == '0))
        else $error("refused operation returned a popped value");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (.*);
